// ===== rtl/jsed_pkg.sv =====
// Shared constants, result bundle type and character helpers for the
// JSON5 string-body unescaper. No dependencies.
`default_nettype none

package jsed_pkg;

  localparam int unsigned COUNT_WIDTH = 13;
  localparam int unsigned CFG_WIDTH   = 13;
  localparam int unsigned BYTE_WIDTH  = 8;
  localparam int unsigned SLOTS       = 4;
  localparam int unsigned CAND_SLOTS  = 3;

  localparam logic [BYTE_WIDTH-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_WIDTH-1:0] CH_X      = 8'h78;
  localparam logic [BYTE_WIDTH-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_WIDTH-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_WIDTH-1:0] CH_B      = 8'h62;
  localparam logic [BYTE_WIDTH-1:0] CH_F      = 8'h66;
  localparam logic [BYTE_WIDTH-1:0] CH_N      = 8'h6E;
  localparam logic [BYTE_WIDTH-1:0] CH_R      = 8'h72;
  localparam logic [BYTE_WIDTH-1:0] CH_T      = 8'h74;
  localparam logic [BYTE_WIDTH-1:0] CH_V      = 8'h76;
  localparam logic [BYTE_WIDTH-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_WIDTH-1:0] CH_NUL    = 8'h00;

  localparam logic [CFG_WIDTH-1:0] MAX_LEN_RESET = 13'd256;

  // Results of one input beat, in order; the last slot used is the
  // terminator when has_last is set.
  typedef struct packed {
    logic [SLOTS-1:0][BYTE_WIDTH-1:0] bytes;
    logic [2:0]                       count;
    logic                             has_last;
  } jsed_bundle_t;

  // {valid, value} of a hex digit
  function automatic logic [4:0] nibble(input logic [BYTE_WIDTH-1:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Single-char escape to its byte; anything unnamed stands for itself
  function automatic logic [BYTE_WIDTH-1:0] esc_map(input logic [BYTE_WIDTH-1:0] c);
    logic [BYTE_WIDTH-1:0] r;
    r = c;
    if (c == CH_B) begin
      r = 8'h08;
    end else if (c == CH_F) begin
      r = 8'h0C;
    end else if (c == CH_N) begin
      r = 8'h0A;
    end else if (c == CH_R) begin
      r = 8'h0D;
    end else if (c == CH_T) begin
      r = 8'h09;
    end else if (c == CH_V) begin
      r = 8'h0B;
    end else if (c == CH_ZERO) begin
      r = CH_NUL;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jsed_in_if.sv =====
// Input channel: one raw string-body byte per beat.
// Uses jsed_pkg for widths.
`default_nettype none

interface jsed_in_if;
  logic                               valid;
  logic                               ready;
  logic [jsed_pkg::BYTE_WIDTH-1:0]    in_byte;
  logic                               end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

// ===== rtl/jsed_out_if.sv =====
// Output channel: one decoded byte or terminator per beat.
// Uses jsed_pkg for widths.
`default_nettype none

interface jsed_out_if;
  logic                               valid;
  logic                               ready;
  logic [jsed_pkg::BYTE_WIDTH-1:0]    out_byte;
  logic                               last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/json_string_escape_decoder.sv =====
// Top level of the JSON5 string-body unescaper.
// Depends on jsed_pkg, jsed_in_if, jsed_out_if, jsed_decode, jsed_result_buf.
//
//   port       dir   beat contents
//   in_ch      sink  in_byte[7:0], end_of_string
//   out_ch     src   out_byte[7:0], last
//   cfg_we     in    write max_out_len from cfg_wdata[12:0]
//
// An input beat is decoded in the cycle it is accepted; its results appear
// from the next cycle, one byte per cycle from the result register while
// out_ch is ready. Input ready stays low until the last result of a beat is
// being taken, so plain text is sustained at one beat per cycle without stalls.
// Synchronous reset empties the result register and returns to plain mode
// with max_out_len 256. Output stalls back up to the input through ready.
`default_nettype none

module json_string_escape_decoder (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [jsed_pkg::CFG_WIDTH-1:0]   cfg_wdata,
  jsed_in_if.sink                               in_ch,
  jsed_out_if.source                            out_ch
);

  jsed_pkg::jsed_bundle_t bundle;
  logic                   in_ready;
  logic                   take;

  assign in_ch.ready = in_ready;
  assign take        = in_ch.valid && in_ready;

  jsed_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .take          (take),
    .in_byte       (in_ch.in_byte),
    .end_of_string (in_ch.end_of_string),
    .bundle        (bundle)
  );

  jsed_result_buf u_result_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .bundle    (bundle),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last),
    .in_ready  (in_ready)
  );

endmodule

`default_nettype wire

// ===== rtl/jsed_decode.sv =====
// Escape state machine, output cap and size register; turns one input beat
// into a bundle of up to four results. Depends on jsed_pkg.
`default_nettype none

module jsed_decode (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [jsed_pkg::CFG_WIDTH-1:0]    cfg_wdata,
  input  wire logic                              take,
  input  wire logic [jsed_pkg::BYTE_WIDTH-1:0]   in_byte,
  input  wire logic                              end_of_string,
  output jsed_pkg::jsed_bundle_t                 bundle
);

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_CR,
    MODE_HEX0,
    MODE_HEX1
  } mode_t;

  localparam logic [jsed_pkg::COUNT_WIDTH-1:0] CMAX = '1;

  mode_t                                mode, mode_next;
  logic [jsed_pkg::BYTE_WIDTH-1:0]      held, held_next;
  logic [jsed_pkg::COUNT_WIDTH-1:0]     count, count_next;
  logic [jsed_pkg::COUNT_WIDTH-1:0]     cap, cap_next;
  logic [jsed_pkg::CFG_WIDTH-1:0]       lim;
  logic [jsed_pkg::COUNT_WIDTH-1:0]     room;
  logic [jsed_pkg::BYTE_WIDTH-1:0]      cand [jsed_pkg::CAND_SLOTS];
  logic [1:0]                           nc;
  logic [1:0]                           n_emit;
  logic                                 plain;
  logic [4:0]                           nib_c, nib_h;

  always_comb begin
    lim = (cfg_wdata == '0) ? '0 : cfg_wdata - 1'b1;
    if ({{(32-jsed_pkg::CFG_WIDTH){1'b0}}, lim} <
        {{(32-jsed_pkg::COUNT_WIDTH){1'b0}}, CMAX}) begin
      cap_next = jsed_pkg::COUNT_WIDTH'(lim);
    end else begin
      cap_next = CMAX;
    end
  end

  assign nib_c = jsed_pkg::nibble(in_byte);
  assign nib_h = jsed_pkg::nibble(held);

  always_comb begin
    for (int i = 0; i < jsed_pkg::CAND_SLOTS; i++) begin
      cand[i] = '0;
    end
    nc        = '0;
    mode_next = mode;
    held_next = held;
    plain     = 1'b0;

    unique case (mode)
      MODE_PLAIN: begin
        plain = 1'b1;
      end
      MODE_ESC: begin
        mode_next = MODE_PLAIN;
        if (in_byte == jsed_pkg::CH_X) begin
          mode_next = MODE_HEX0;
        end else if (in_byte == jsed_pkg::CH_CR) begin
          mode_next = MODE_CR;
        end else if (in_byte != jsed_pkg::CH_LF) begin
          cand[nc] = jsed_pkg::esc_map(in_byte);
          nc       = nc + 2'd1;
        end
      end
      MODE_CR: begin
        mode_next = MODE_PLAIN;
        plain     = (in_byte != jsed_pkg::CH_LF);
      end
      MODE_HEX0: begin
        if (nib_c[4]) begin
          held_next = in_byte;
          mode_next = MODE_HEX1;
        end else begin
          cand[nc] = jsed_pkg::CH_X;
          nc       = nc + 2'd1;
          plain    = 1'b1;
        end
      end
      MODE_HEX1: begin
        if (nib_h[4] && nib_c[4]) begin
          mode_next = MODE_PLAIN;
          cand[nc]  = {nib_h[3:0], nib_c[3:0]};
          nc        = nc + 2'd1;
        end else begin
          cand[nc] = jsed_pkg::CH_X;
          nc       = nc + 2'd1;
          cand[nc] = held;
          nc       = nc + 2'd1;
          plain    = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_PLAIN;
      end
    endcase

    if (plain) begin
      if (in_byte == jsed_pkg::CH_BSLASH) begin
        mode_next = MODE_ESC;
      end else begin
        mode_next = MODE_PLAIN;
        cand[nc]  = in_byte;
        nc        = nc + 2'd1;
      end
    end

    // flush an unfinished escape at the end of the string
    if (end_of_string) begin
      if (mode_next == MODE_ESC) begin
        cand[nc] = jsed_pkg::CH_BSLASH;
        nc       = nc + 2'd1;
      end else if (mode_next == MODE_HEX0) begin
        cand[nc] = jsed_pkg::CH_X;
        nc       = nc + 2'd1;
      end else if (mode_next == MODE_HEX1) begin
        cand[nc] = jsed_pkg::CH_X;
        nc       = nc + 2'd1;
        cand[nc] = held_next;
        nc       = nc + 2'd1;
      end
      mode_next = MODE_PLAIN;
      held_next = '0;
    end
  end

  always_comb begin
    room = (cap > count) ? cap - count : '0;
    if (room >= {{(jsed_pkg::COUNT_WIDTH-2){1'b0}}, nc}) begin
      n_emit = nc;
    end else begin
      n_emit = room[1:0];
    end
    count_next = end_of_string ? '0 : count + {{(jsed_pkg::COUNT_WIDTH-2){1'b0}}, n_emit};

    for (int i = 0; i < jsed_pkg::CAND_SLOTS; i++) begin
      bundle.bytes[i] = (2'(i) < n_emit) ? cand[i] : jsed_pkg::CH_NUL;
    end
    bundle.bytes[jsed_pkg::SLOTS-1] = jsed_pkg::CH_NUL;
    bundle.count    = {1'b0, n_emit} + {2'b0, end_of_string};
    bundle.has_last = end_of_string;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_PLAIN;
      held  <= '0;
      count <= '0;
      cap   <= jsed_pkg::COUNT_WIDTH'(jsed_pkg::MAX_LEN_RESET - 1'b1);
    end else begin
      if (cfg_we) begin
        cap <= cap_next;
      end
      if (take) begin
        mode  <= mode_next;
        held  <= held_next;
        count <= count_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jsed_result_buf.sv =====
// Result register: holds one beat's bundle and plays it out one byte per
// cycle while out_ready is high. Depends on jsed_pkg.
`default_nettype none

module jsed_result_buf (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  jsed_pkg::jsed_bundle_t                 bundle,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [jsed_pkg::BYTE_WIDTH-1:0]        out_byte,
  output logic                                   out_last,
  output logic                                   in_ready
);

  logic [jsed_pkg::SLOTS-1:0][jsed_pkg::BYTE_WIDTH-1:0] bytes;
  logic [1:0] rd;
  logic [2:0] rem;
  logic       has_last;

  assign out_valid = (rem != '0);
  assign out_byte  = bytes[rd];
  assign out_last  = has_last && (rem == 3'd1);
  assign in_ready  = (rem == '0) || (out_ready && rem == 3'd1);

  always_ff @(posedge clk) begin
    if (load) begin
      bytes    <= bundle.bytes;
      has_last <= bundle.has_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd  <= '0;
      rem <= '0;
    end else if (load) begin
      rd  <= '0;
      rem <= bundle.count;
    end else if (out_valid && out_ready) begin
      rd  <= rd + 2'd1;
      rem <= rem - 3'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jsed_checker.sv =====
// Port-level checks for json_string_escape_decoder, bound to the top level.
// Depends on jsed_pkg.
`default_nettype none

module jsed_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [jsed_pkg::BYTE_WIDTH-1:0]  out_byte,
  input wire logic                             out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready with empty result register");

  a_term_nul: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_byte == jsed_pkg::CH_NUL)
    else $error("terminator beat not NUL");

endmodule

bind json_string_escape_decoder jsed_checker u_jsed_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last)
);

`default_nettype wire

// ===== bench/json_string_escape_decoder_chk.sv =====
// Scoreboard for json_string_escape_decoder: follows the size register and both
// channels, works out the unescaped bytes of every input beat and compares them.
// Depends on jsed_pkg, jsed_in_if and jsed_out_if.
module json_string_escape_decoder_chk (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [jsed_pkg::CFG_WIDTH-1:0] cfg_wdata,
  jsed_in_if                             in_ch,
  jsed_out_if                            out_ch,
  output int                             outstanding,
  output int                             fails
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {ESC_NONE, ESC_SEEN, ESC_CR, ESC_HEX_0, ESC_HEX_1} esc_state_t;

  typedef struct packed {
    logic [jsed_pkg::BYTE_WIDTH-1:0] data;
    logic                            last;
  } dec_beat_t;

  dec_beat_t                        decoded_q[$];
  esc_state_t                       esc_state = ESC_NONE;
  logic [jsed_pkg::BYTE_WIDTH-1:0]  hex_hi = '0;
  logic [jsed_pkg::COUNT_WIDTH-1:0] n_decoded = '0;
  logic [jsed_pkg::CFG_WIDTH-1:0]   dest_size = jsed_pkg::MAX_LEN_RESET;
  int                               err_cnt = 0;

  function automatic void note_fail(input string msg);
    err_cnt++;
    $error("%s", msg);
  endfunction

  function automatic logic is_hex(input logic [jsed_pkg::BYTE_WIDTH-1:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [jsed_pkg::BYTE_WIDTH-1:0] c);
    if (c <= "9") begin
      return 4'(c - "0");
    end
    return 4'((c | 8'h20) - "a" + 8'd10);
  endfunction

  // drop once the destination is full, keeping room for the terminator
  function automatic void put_decoded(input logic [jsed_pkg::BYTE_WIDTH-1:0] b);
    logic [jsed_pkg::CFG_WIDTH-1:0] room;
    room = (dest_size == '0) ? '0 : dest_size - 1'b1;
    if (n_decoded < room) begin
      decoded_q.push_back('{data: b, last: 1'b0});
      n_decoded++;
    end
  endfunction

  function automatic void take_literal(input logic [jsed_pkg::BYTE_WIDTH-1:0] c);
    if (c == jsed_pkg::CH_BSLASH) begin
      esc_state = ESC_SEEN;
    end else begin
      esc_state = ESC_NONE;
      put_decoded(c);
    end
  endfunction

  function automatic void take_escaped(input logic [jsed_pkg::BYTE_WIDTH-1:0] c);
    esc_state = ESC_NONE;
    case (c)
      jsed_pkg::CH_B:    put_decoded(8'h08);
      jsed_pkg::CH_F:    put_decoded(8'h0C);
      jsed_pkg::CH_N:    put_decoded(jsed_pkg::CH_LF);
      jsed_pkg::CH_R:    put_decoded(jsed_pkg::CH_CR);
      jsed_pkg::CH_T:    put_decoded(8'h09);
      jsed_pkg::CH_V:    put_decoded(8'h0B);
      jsed_pkg::CH_ZERO: put_decoded(jsed_pkg::CH_NUL);
      jsed_pkg::CH_X:    esc_state = ESC_HEX_0;
      jsed_pkg::CH_LF:   ;
      jsed_pkg::CH_CR:   esc_state = ESC_CR;
      default:           put_decoded(c);
    endcase
  endfunction

  function automatic void decode_beat(input logic [jsed_pkg::BYTE_WIDTH-1:0] c,
                                      input logic eos);
    case (esc_state)
      ESC_SEEN: take_escaped(c);
      ESC_CR: begin
        esc_state = ESC_NONE;
        if (c != jsed_pkg::CH_LF) begin
          take_literal(c);
        end
      end
      ESC_HEX_0: begin
        if (is_hex(c)) begin
          hex_hi = c;
          esc_state = ESC_HEX_1;
        end else begin
          put_decoded(jsed_pkg::CH_X);
          take_literal(c);
        end
      end
      ESC_HEX_1: begin
        if (is_hex(c)) begin
          esc_state = ESC_NONE;
          put_decoded({hex_val(hex_hi), hex_val(c)});
        end else begin
          put_decoded(jsed_pkg::CH_X);
          put_decoded(hex_hi);
          take_literal(c);
        end
      end
      default: take_literal(c);
    endcase
    if (eos) begin
      // flush whatever escape was left open
      case (esc_state)
        ESC_SEEN:  put_decoded(jsed_pkg::CH_BSLASH);
        ESC_HEX_0: put_decoded(jsed_pkg::CH_X);
        ESC_HEX_1: begin
          put_decoded(jsed_pkg::CH_X);
          put_decoded(hex_hi);
        end
        default: ;
      endcase
      decoded_q.push_back('{data: jsed_pkg::CH_NUL, last: 1'b1});
      esc_state = ESC_NONE;
      hex_hi = '0;
      n_decoded = '0;
    end
  endfunction

  always @(posedge clk) begin
    dec_beat_t want;
    if (rst) begin
      decoded_q.delete();
      esc_state = ESC_NONE;
      hex_hi = '0;
      n_decoded = '0;
      dest_size = jsed_pkg::MAX_LEN_RESET;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          note_fail($sformatf("unexpected beat: out_byte %02h last %0b",
                              out_ch.out_byte, out_ch.last));
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.data) begin
            note_fail($sformatf("out_byte: expected %02h, actual %02h",
                                want.data, out_ch.out_byte));
          end
          if (out_ch.last !== want.last) begin
            note_fail($sformatf("last: expected %0b, actual %0b", want.last, out_ch.last));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_beat(in_ch.in_byte, in_ch.end_of_string);
      end
      if (cfg_we) begin
        dest_size = cfg_wdata;
      end
    end
    outstanding <= decoded_q.size();
    fails <= err_cnt;
  end

endmodule

// ===== bench/json_string_escape_decoder_tb.sv =====
// Top of the json_string_escape_decoder bench: clock, reset, size register
// writes, string stimulus and random back-pressure; the verdict comes from
// json_string_escape_decoder_chk. Depends on jsed_pkg and both channel interfaces.
module json_string_escape_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 120;
  localparam int RANDOM_ITEMS = 260;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [jsed_pkg::CFG_WIDTH-1:0] cfg_wdata = '0;
  int                             outstanding;
  int                             fails;
  int                             idle_pct = 0;
  bit                             hold_off = 1'b0;
  int                             sent = 0;
  int                             quiet_cycles = 0;
  logic [7:0]                     str_q[$];
  string                          hex_digits = "0123456789abcdefABCDEF";
  string                          esc_letters = "bfnrtv0\"\\/'";

  jsed_in_if  in_ch ();
  jsed_out_if out_ch ();

  json_string_escape_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  json_string_escape_decoder_chk chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .outstanding (outstanding),
    .fails       (fails)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int gap_cycles();
    if (idle_pct == 0 || $urandom_range(99) >= idle_pct) begin
      return 0;
    end
    if ($urandom_range(19) == 0) begin
      return $urandom_range(40, 10);
    end
    return $urandom_range(3, 1);
  endfunction

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (!rst);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        gap = gap_cycles();
        if (gap == 0) begin
          out_ch.ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  task automatic put_beat(input logic [7:0] b, input logic eos);
    int gap;
    gap = gap_cycles();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.end_of_string <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    str_q.push_back(b);
  endfunction

  function automatic void add_text(input string s);
    foreach (s[i]) begin
      str_q.push_back(s[i]);
    end
  endfunction

  task automatic send_str();
    foreach (str_q[i]) begin
      put_beat(str_q[i], i == str_q.size() - 1);
    end
    str_q.delete();
  endtask

  function automatic logic [7:0] hex_char();
    return hex_digits[$urandom_range(hex_digits.len() - 1)];
  endfunction

  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(8'hFF, 8'h67));
      1:       return 8'($urandom_range(8'h2F, 8'h00));
      2:       return jsed_pkg::CH_BSLASH;
      default: return "G";
    endcase
  endfunction

  function automatic void add_piece();
    case ($urandom_range(9))
      0, 1, 2: add_byte(8'($urandom_range(255)));
      3: begin
        add_byte(jsed_pkg::CH_BSLASH);
        add_byte(esc_letters[$urandom_range(esc_letters.len() - 1)]);
      end
      4: begin
        add_byte(jsed_pkg::CH_BSLASH);
        add_byte(8'($urandom_range(255)));
      end
      5: begin
        add_byte(jsed_pkg::CH_BSLASH);
        add_byte(jsed_pkg::CH_X);
        add_byte(hex_char());
        add_byte(hex_char());
      end
      6: begin
        add_byte(jsed_pkg::CH_BSLASH);
        add_byte(jsed_pkg::CH_X);
        if ($urandom_range(1)) begin
          add_byte(hex_char());
        end
        add_byte(non_hex_char());
      end
      7: begin
        add_byte(jsed_pkg::CH_BSLASH);
        add_byte(jsed_pkg::CH_CR);
        if ($urandom_range(3) != 0) begin
          add_byte(jsed_pkg::CH_LF);
        end
      end
      8: begin
        add_byte(jsed_pkg::CH_BSLASH);
        add_byte(jsed_pkg::CH_LF);
      end
      default: begin
        repeat (3) add_byte(8'($urandom_range(8'h7E, 8'h20)));
      end
    endcase
  endfunction

  function automatic void add_random_string(input int pieces);
    repeat (pieces) add_piece();
    // now and then end the string inside an escape
    case ($urandom_range(7))
      0: add_byte(jsed_pkg::CH_BSLASH);
      1: begin
        add_byte(jsed_pkg::CH_BSLASH);
        add_byte(jsed_pkg::CH_X);
      end
      2: begin
        add_byte(jsed_pkg::CH_BSLASH);
        add_byte(jsed_pkg::CH_X);
        add_byte(hex_char());
      end
      3: begin
        add_byte(jsed_pkg::CH_BSLASH);
        add_byte(jsed_pkg::CH_CR);
      end
      default: ;
    endcase
  endfunction

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_dest_size(input logic [jsed_pkg::CFG_WIDTH-1:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [jsed_pkg::CFG_WIDTH-1:0] sizes[$];
    int                             target;
    sizes = '{13'd300, 13'd0, 13'd1, 13'd2, 13'd3, 13'd7, 13'd16, 13'd4096, 13'd8191};
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.end_of_string <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 20;
    put_beat(8'h00, 1'b0);
    put_beat(8'hFF, 1'b1);
    add_text("\\b\\f\\n\\r\\t\\v\\0");
    send_str();
    add_text("\\xAz");
    send_str();
    add_text("\\\n\\\r\n");
    send_str();
    add_text("\\");
    send_str();
    add_text("\\x");
    send_str();
    settle();

    foreach (sizes[i]) begin
      set_dest_size(sizes[i]);
      idle_pct = (i % 3 == 0) ? 0 : ((i % 3 == 1) ? 15 : 45);
      if (i == 0) begin
        hold_off = 1'b1;
      end
      target = RANDOM_ITEMS * (i + 1) / sizes.size();
      do begin
        if (i == 0 || $urandom_range(5) == 0) begin
          add_random_string($urandom_range(25, 12));
        end else begin
          add_random_string($urandom_range(6, 1));
        end
        send_str();
      end while (sent < target);
      settle();
    end

    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
